FILE: src/mvna_pkg.sv
`default_nettype none
package mvna_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam int unsigned IdxW   = 12;
  localparam int unsigned CrdW   = 20;
  localparam int unsigned SumW   = 49;
  localparam int unsigned NrmW   = 16;
  localparam int unsigned MagW   = 48;
  localparam int unsigned RootW  = 51;
  localparam int unsigned SqW    = 98;
  localparam int unsigned ProdW  = 64;
  localparam logic [15:0] UnitScale = 16'd32767;

  // One classified command as it travels from the front end to the back end.
  typedef struct packed {
    cmd_e             cmd;
    logic             in_range;
    logic [IdxW-1:0]  idx_a;
    logic [IdxW-1:0]  idx_b;
    logic [IdxW-1:0]  idx_c;
    logic [CrdW-1:0]  px;
    logic [CrdW-1:0]  py;
    logic [CrdW-1:0]  pz;
  } work_t;

endpackage
`default_nettype wire

FILE: src/mvna_front.sv
`default_nettype none
module mvna_front import mvna_pkg::*; #(
  parameter int unsigned MaxVertices = 4096,
  parameter int unsigned CoordBits   = 20
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic [1:0]      cmd_i,
  input  wire logic [IdxW-1:0] vertex_index_i,
  input  wire logic [CrdW-1:0] pos_x_i,
  input  wire logic [CrdW-1:0] pos_y_i,
  input  wire logic [CrdW-1:0] pos_z_i,
  input  wire logic [IdxW-1:0] corner_a_i,
  input  wire logic [IdxW-1:0] corner_b_i,
  input  wire logic [IdxW-1:0] corner_c_i,
  output logic                 q_valid_o,
  output work_t                q_data_o,
  input  wire logic            q_pop_i
);

  // Two-entry queue.
  work_t     mem_q [2];
  logic      wp_q, rp_q;
  logic [1:0] cnt_q;
  logic      push;
  work_t     w;

  function automatic logic [CrdW-1:0] sext(input logic [CrdW-1:0] v);
    logic [CrdW-1:0] r;
    for (int i = 0; i < CrdW; i++) begin
      r[i] = (i < CoordBits) ? v[i] : v[CoordBits-1];
    end
    return r;
  endfunction

  always_comb begin
    w = '0;
    w.cmd = cmd_e'(cmd_i);
    w.px = sext(pos_x_i);
    w.py = sext(pos_y_i);
    w.pz = sext(pos_z_i);
    if (cmd_i == CMD_TRI) begin
      w.idx_a = corner_a_i;
      w.idx_b = corner_b_i;
      w.idx_c = corner_c_i;
      w.in_range = (32'(corner_a_i) < MaxVertices) && (32'(corner_b_i) < MaxVertices)
                   && (32'(corner_c_i) < MaxVertices);
    end else begin
      w.idx_a = vertex_index_i;
      w.idx_b = vertex_index_i;
      w.idx_c = vertex_index_i;
      w.in_range = 32'(vertex_index_i) < MaxVertices;
    end
  end

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o && (cmd_i != CMD_NONE);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule
`default_nettype wire

FILE: src/mvna_back.sv
`default_nettype none
module mvna_back import mvna_pkg::*; #(
  parameter int unsigned MaxVertices = 4096
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  work_t                 q_data_i,
  output logic                  q_pop_o,
  output logic                  done_o,
  output logic [IdxW-1:0]       read_index_o,
  output logic signed [NrmW-1:0] normal_x_o,
  output logic signed [NrmW-1:0] normal_y_o,
  output logic signed [NrmW-1:0] normal_z_o,
  output logic                  degenerate_o,
  output logic                  idle_o
);

  localparam int unsigned AW = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned HalfW = 24;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_PRD0  = 15'b000000000000010,
    S_PRD1  = 15'b000000000000100,
    S_PRD2  = 15'b000000000001000,
    S_CROSS = 15'b000000000010000,
    S_MULA  = 15'b000000000100000,
    S_MULB  = 15'b000000001000000,
    S_SRD   = 15'b000000010000000,
    S_SWR   = 15'b000000100000000,
    S_RRD   = 15'b000001000000000,
    S_SQ    = 15'b000010000000000,
    S_ROOT  = 15'b000100000000000,
    S_DIVP  = 15'b001000000000000,
    S_DIV   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q;
  work_t  job_q;

  logic [3*CrdW-1:0] pos_mem [MaxVertices];
  logic [3*SumW-1:0] sum_mem [MaxVertices];

  logic [3*CrdW-1:0] pos_rd_q;
  logic [3*SumW-1:0] sum_rd_q;
  logic [AW-1:0]     pos_ra, sum_ra, sum_wa;
  logic              sum_we;
  logic [3*SumW-1:0] sum_wd;

  logic signed [CrdW:0] ax_q, ay_q, az_q, e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [2*CrdW+2:0] p_q [6];
  logic signed [SumW-1:0] n_q [3];
  logic [1:0] k_q;

  // Read path.
  logic [MagW:0]   m_q [3];
  logic signed [SumW-1:0] s_q [3];
  logic [1:0]      sq_i_q;
  logic [1:0]      pp_q;
  logic [SqW-1:0]  norm_q;
  logic [RootW-1:0] root_q;
  logic [RootW+1:0] rem_rt_q;
  logic [5:0]      bit_q;
  logic [ProdW-1:0] num_q [3];
  logic [ProdW-1:0] quo_q [3];
  logic [ProdW:0]  rem_q [3];
  logic [6:0]      dcnt_q;
  logic            dgn_q;

  function automatic logic [AW-1:0] ix(input logic [IdxW-1:0] v);
    return AW'(v);
  endfunction

  function automatic logic signed [SumW-1:0] sat(input logic signed [SumW+1:0] v);
    if (v > $signed({3'b000, {(SumW-1){1'b1}}})) return {1'b0, {(SumW-1){1'b1}}};
    if (v < $signed({3'b111, {(SumW-1){1'b0}}})) return {1'b1, {(SumW-1){1'b0}}};
    return v[SumW-1:0];
  endfunction

  logic [AW-1:0] corner;
  always_comb begin
    unique case (k_q)
      2'd0: corner = ix(job_q.idx_a);
      2'd1: corner = ix(job_q.idx_b);
      default: corner = ix(job_q.idx_c);
    endcase
  end

  // Each square is built from three partial products of the high and low
  // halves of the magnitude, one partial product per cycle.
  logic [MagW:0]               sq_m;
  logic [MagW-HalfW:0]         mul_a, mul_b;
  logic [2*(MagW-HalfW+1)-1:0] mul_p;
  logic [SqW-1:0]              pp_term;

  always_comb begin
    sq_m = m_q[sq_i_q];
    case (pp_q)
      2'd0: begin
        mul_a = sq_m[MagW:HalfW];
        mul_b = sq_m[MagW:HalfW];
      end
      2'd1: begin
        mul_a = sq_m[MagW:HalfW];
        mul_b = {1'b0, sq_m[HalfW-1:0]};
      end
      default: begin
        mul_a = {1'b0, sq_m[HalfW-1:0]};
        mul_b = {1'b0, sq_m[HalfW-1:0]};
      end
    endcase
    mul_p = mul_a * mul_b;
    case (pp_q)
      2'd0: pp_term = SqW'(mul_p) << (2*HalfW);
      2'd1: pp_term = SqW'(mul_p) << (HalfW+1);
      default: pp_term = SqW'(mul_p);
    endcase
  end

  // Digit-by-digit square root: two radicand bits enter the remainder per step.
  logic [RootW+1:0] rt_shift, rt_trial;
  assign rt_shift = {rem_rt_q[RootW-1:0], norm_q[SqW-1 -: 2]};
  assign rt_trial = {root_q, 2'b01};

  always_comb begin
    pos_ra = corner;
    sum_ra = (state_q == S_IDLE) ? ix(q_data_i.idx_a) :
             (state_q == S_RRD) ? ix(job_q.idx_a) : corner;
    sum_wa = corner;
    sum_we = 1'b0;
    sum_wd = '0;
    if (state_q == S_SWR) begin
      sum_we = 1'b1;
      sum_wd = {sat((SumW+2)'($signed(sum_rd_q[3*SumW-1:2*SumW])) + (SumW+2)'(n_q[0])),
                sat((SumW+2)'($signed(sum_rd_q[2*SumW-1:SumW])) + (SumW+2)'(n_q[1])),
                sat((SumW+2)'($signed(sum_rd_q[SumW-1:0])) + (SumW+2)'(n_q[2]))};
    end
  end

  always_ff @(posedge clk_i) begin
    pos_rd_q <= pos_mem[pos_ra];
    sum_rd_q <= sum_mem[sum_ra];
    if (state_q == S_PRD0 && job_q.cmd == CMD_WRITE) begin
      pos_mem[ix(job_q.idx_a)] <= {job_q.px, job_q.py, job_q.pz};
      sum_mem[ix(job_q.idx_a)] <= '0;
    end else if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign idle_o  = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
      k_q     <= 2'd0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          k_q <= 2'd0;
          if (q_valid_i) begin
            job_q <= q_data_i;
            if (!q_data_i.in_range) begin
              state_q <= (q_data_i.cmd == CMD_READ) ? S_OUT : S_IDLE;
              dgn_q <= 1'b1;
              for (int i = 0; i < 3; i++) quo_q[i] <= '0;
            end else if (q_data_i.cmd == CMD_READ) begin
              state_q <= S_RRD;
            end else begin
              state_q <= S_PRD0;
            end
          end
        end
        S_PRD0: begin
          if (job_q.cmd == CMD_WRITE) state_q <= S_IDLE;
          else begin
            k_q <= 2'd1;
            state_q <= S_PRD1;
          end
        end
        S_PRD1: begin
          ax_q <= $signed(pos_rd_q[3*CrdW-1:2*CrdW]);
          ay_q <= $signed(pos_rd_q[2*CrdW-1:CrdW]);
          az_q <= $signed(pos_rd_q[CrdW-1:0]);
          k_q <= 2'd2;
          state_q <= S_PRD2;
        end
        S_PRD2: begin
          e1x_q <= $signed(pos_rd_q[3*CrdW-1:2*CrdW]) - ax_q;
          e1y_q <= $signed(pos_rd_q[2*CrdW-1:CrdW]) - ay_q;
          e1z_q <= $signed(pos_rd_q[CrdW-1:0]) - az_q;
          state_q <= S_CROSS;
        end
        S_CROSS: begin
          e2x_q <= $signed(pos_rd_q[3*CrdW-1:2*CrdW]) - ax_q;
          e2y_q <= $signed(pos_rd_q[2*CrdW-1:CrdW]) - ay_q;
          e2z_q <= $signed(pos_rd_q[CrdW-1:0]) - az_q;
          state_q <= S_MULA;
        end
        S_MULA: begin
          p_q[0] <= (2*CrdW+3)'(e1y_q * e2z_q);
          p_q[1] <= (2*CrdW+3)'(e1z_q * e2y_q);
          p_q[2] <= (2*CrdW+3)'(e1z_q * e2x_q);
          p_q[3] <= (2*CrdW+3)'(e1x_q * e2z_q);
          p_q[4] <= (2*CrdW+3)'(e1x_q * e2y_q);
          p_q[5] <= (2*CrdW+3)'(e1y_q * e2x_q);
          state_q <= S_MULB;
        end
        S_MULB: begin
          n_q[0] <= SumW'(p_q[0] - p_q[1]);
          n_q[1] <= SumW'(p_q[2] - p_q[3]);
          n_q[2] <= SumW'(p_q[4] - p_q[5]);
          k_q <= 2'd0;
          state_q <= S_SRD;
        end
        S_SRD: state_q <= S_SWR;
        S_SWR: begin
          if (k_q == 2'd2) state_q <= S_IDLE;
          else begin
            k_q <= k_q + 2'd1;
            state_q <= S_SRD;
          end
        end
        S_RRD: begin
          s_q[2] <= $signed(sum_rd_q[3*SumW-1:2*SumW]);
          s_q[1] <= $signed(sum_rd_q[2*SumW-1:SumW]);
          s_q[0] <= $signed(sum_rd_q[SumW-1:0]);
          for (int i = 0; i < 3; i++) begin
            m_q[i] <= sum_rd_q[i*SumW+SumW-1] ? (MagW+1)'(-$signed(sum_rd_q[i*SumW +: SumW]))
                                            : (MagW+1)'(sum_rd_q[i*SumW +: SumW]);
          end
          norm_q <= '0;
          sq_i_q <= 2'd0;
          pp_q <= 2'd0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          // One partial product per cycle, accumulated.
          norm_q <= norm_q + pp_term;
          if (pp_q == 2'd2) begin
            pp_q <= 2'd0;
            if (sq_i_q == 2'd2) begin
              root_q <= '0;
              rem_rt_q <= '0;
              bit_q <= 6'(SqW/2 - 1);
              state_q <= S_ROOT;
            end else sq_i_q <= sq_i_q + 2'd1;
          end else pp_q <= pp_q + 2'd1;
        end
        S_ROOT: begin
          if (rt_shift >= rt_trial) begin
            rem_rt_q <= rt_shift - rt_trial;
            root_q <= {root_q[RootW-2:0], 1'b1};
          end else begin
            rem_rt_q <= rt_shift;
            root_q <= {root_q[RootW-2:0], 1'b0};
          end
          norm_q <= norm_q << 2;
          if (bit_q == 6'd0) state_q <= S_DIVP;
          else bit_q <= bit_q - 6'd1;
        end
        S_DIVP: begin
          for (int i = 0; i < 3; i++) begin
            num_q[i] <= ProdW'(m_q[i] * UnitScale);
            quo_q[i] <= '0;
            rem_q[i] <= '0;
          end
          dgn_q <= (root_q == '0);
          dcnt_q <= 7'(ProdW);
          state_q <= (root_q == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle for all three lanes.
          for (int i = 0; i < 3; i++) begin
            logic [ProdW:0] t;
            t = {rem_q[i][ProdW-1:0], num_q[i][ProdW-1]};
            num_q[i] <= num_q[i] << 1;
            if (t >= (ProdW+1)'(root_q)) begin
              rem_q[i] <= t - (ProdW+1)'(root_q);
              quo_q[i] <= {quo_q[i][ProdW-2:0], 1'b1};
            end else begin
              rem_q[i] <= t;
              quo_q[i] <= {quo_q[i][ProdW-2:0], 1'b0};
            end
          end
          if (dcnt_q == 7'd1) state_q <= S_OUT;
          dcnt_q <= dcnt_q - 7'd1;
        end
        S_OUT: begin
          done_o <= 1'b1;
          read_index_o <= job_q.idx_a;
          degenerate_o <= dgn_q;
          normal_x_o <= (dgn_q) ? '0 : (s_q[2][SumW-1] ? -NrmW'(quo_q[2]) : NrmW'(quo_q[2]));
          normal_y_o <= (dgn_q) ? '0 : (s_q[1][SumW-1] ? -NrmW'(quo_q[1]) : NrmW'(quo_q[1]));
          normal_z_o <= (dgn_q) ? '0 : (s_q[0][SumW-1] ? -NrmW'(quo_q[0]) : NrmW'(quo_q[0]));
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/mesh_vertex_normal_accumulator.sv
// Channel   | Direction | Ports                                        | Handshake
// command   | in        | cmd_i, vertex_index_i, pos_*_i, corner_*_i   | start_i & !busy_o
// result    | out       | read_index_o, normal_*_o, degenerate_o        | done_o, one cycle
//
// In the back end a write stores the position and clears the sum in S_PRD0; a
// triangle makes three position reads on the single read port, forms products in
// S_MULA and differences in S_MULB, then three read-modify-writes of the sum memory;
// a read forms nine partial products for the squares, 49 root steps and 64 shared
// divider steps. Reset clears only control state; the memories are undefined until
// written. The two-beat queue lets commands be taken while the back end works; busy_o
// rises when it is full. The receiver cannot stall, so results are never held.
`default_nettype none
module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
  parameter int unsigned MaxVertices = 4096,
  parameter int unsigned CoordBits   = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           cmd_i,
  input  wire logic [IdxW-1:0]      vertex_index_i,
  input  wire logic [CrdW-1:0]      pos_x_i,
  input  wire logic [CrdW-1:0]      pos_y_i,
  input  wire logic [CrdW-1:0]      pos_z_i,
  input  wire logic [IdxW-1:0]      corner_a_i,
  input  wire logic [IdxW-1:0]      corner_b_i,
  input  wire logic [IdxW-1:0]      corner_c_i,
  output logic                      done_o,
  output logic [IdxW-1:0]           read_index_o,
  output logic signed [NrmW-1:0]    normal_x_o,
  output logic signed [NrmW-1:0]    normal_y_o,
  output logic signed [NrmW-1:0]    normal_z_o,
  output logic                      degenerate_o
);

  logic  q_valid, q_pop, back_idle;
  work_t q_data;

  // The front end classifies and range-checks each beat and queues every command but CMD_NONE.
  mvna_front #(.MaxVertices(MaxVertices), .CoordBits(CoordBits)) u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_i, .vertex_index_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .corner_a_i, .corner_b_i, .corner_c_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  // The back end owns the memories and the arithmetic.
  mvna_back #(.MaxVertices(MaxVertices)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .done_o, .read_index_o, .normal_x_o, .normal_y_o, .normal_z_o,
    .degenerate_o, .idle_o(back_idle)
  );

  // A pop only happens when the back end is idle and the queue holds a beat.
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_valid && back_idle)) else $error("pop without work");

  // A result appears only while the back end is idle, waiting for work.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> back_idle) else $error("result outside idle");

  // A degenerate result carries a zero vector.
  a_dgn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |-> (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("degenerate with nonzero normal");

endmodule
`default_nettype wire
